// ===== rtl/ngfa_pkg.sv =====
// ----------------------------------------------------------------------------
// ngfa_pkg
// Shared types and constants of the 2D direct-sum gravity force accumulator.
// ----------------------------------------------------------------------------
package ngfa_pkg;

  // Default capacity of the body store.
  localparam int unsigned MAX_BODIES_DEF = 64;

  // Field widths.
  localparam int unsigned POS_W   = 32;
  localparam int unsigned MASS_W  = 32;
  localparam int unsigned FORCE_W = 48;
  localparam int unsigned IDX_W   = 6;

  // Entries of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Iteration counts of the pair unit.
  localparam int unsigned ROOT_STEPS = 50;
  localparam int unsigned UNIT_STEPS = 16;

  // G scaled into Q.16 is 1000 * 65536; the 65536 is folded into a shift.
  localparam logic [9:0]  GRAV_K     = 10'd1000;
  // Squared distance floor, 1.0 in Q.16.
  localparam logic [66:0] DIST_FLOOR = 67'd65536;
  // Unit vector component 1.0 in Q.16.
  localparam logic [16:0] UNIT_ONE   = 17'h10000;

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = 48'sh8000_0000_0000;

  // One body as held in the store.
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [MASS_W-1:0]       m;
  } body_t;

  // Classified load transaction passed from front to back.
  typedef struct packed {
    body_t body;
    logic  keep;
    logic  last;
  } cmd_t;

  // Result of one pair evaluation.
  typedef struct packed {
    logic signed [FORCE_W-1:0] cx;
    logic signed [FORCE_W-1:0] cy;
    logic                      sat;
  } pair_res_t;

  typedef enum logic [3:0] {
    P_IDLE, P_MUL, P_PREP, P_ROOT, P_UPREP, P_UDIV, P_SCALE, P_SIGN, P_DONE
  } pair_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_RD_I, B_GET_I, B_RD_J, B_GET_J, B_PAIR, B_EMIT
  } back_state_e;

endpackage

// ===== rtl/ngfa_ram.sv =====
// ----------------------------------------------------------------------------
// ngfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ngfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ngfa_queue.sv =====
// ----------------------------------------------------------------------------
// ngfa_queue
// Short command queue that decouples the load front from the compute back.
// ----------------------------------------------------------------------------
module ngfa_queue import ngfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/ngfa_front.sv =====
// ----------------------------------------------------------------------------
// ngfa_front
// Accepts load transactions and marks each as stored or dropped for capacity.
// ----------------------------------------------------------------------------
module ngfa_front import ngfa_pkg::*; #(
  parameter int unsigned MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [POS_W-1:0] body_x_i,
  input  logic signed [POS_W-1:0] body_y_i,
  input  logic [MASS_W-1:0]       body_mass_i,
  input  logic                    last_body_i,
  input  logic                    full_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  logic [CW-1:0] count_q, count_d;
  logic          keep;

  assign keep   = (count_q < CW'(MAX_BODIES));
  assign push_o = start_i && !full_i;

  // Build the classified command.
  always_comb begin
    cmd_o.body.x = body_x_i;
    cmd_o.body.y = body_y_i;
    cmd_o.body.m = body_mass_i;
    cmd_o.keep   = keep;
    cmd_o.last   = last_body_i;
  end

  // Count stored bodies of the current set.
  always_comb begin
    count_d = count_q;
    if (push_o) begin
      if (last_body_i) begin
        count_d = '0;
      end else if (keep) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/ngfa_pair.sv =====
// ----------------------------------------------------------------------------
// ngfa_pair
// Iterative unit that evaluates the pull of one body j on one body i.
// ----------------------------------------------------------------------------
module ngfa_pair import ngfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  body_t     bi_i,
  input  body_t     bj_i,
  output logic      done_o,
  output pair_res_t res_o
);

  pair_state_e state_q, state_d;

  logic [32:0]  dx, dy, absx, absy;
  logic [32:0]  ax_q, ay_q;
  logic         sx_q, sy_q;
  logic [63:0]  mm_q;
  logic [65:0]  sqx_q, sqy_q;
  logic [73:0]  num_q;
  logic [66:0]  d2, dc, dc_q;
  logic         fsat, fsat_q;
  logic [66:0]  dr_q, dnext;
  logic [67:0]  dtry;
  logic         dge;
  logic [49:0]  dq_q, nsh_q;
  logic [99:0]  v_q;
  logic [49:0]  root_q;
  logic [52:0]  srem_q, stry, trial;
  logic         sge;
  logic [5:0]   cnt_q;
  logic [49:0]  rx_q, ry_q;
  logic [50:0]  xtry, ytry, xsub, ysub;
  logic         xge, yge;
  logic [15:0]  qx_q, qy_q;
  logic         clx_q, cly_q;
  logic [46:0]  f_q;
  logic [16:0]  uxv, uyv;
  logic [63:0]  prodx, prody;
  logic [47:0]  px_q, py_q;
  pair_res_t    res_q;

  // Separation and its magnitude.
  assign dx   = {bj_i.x[31], bj_i.x} - {bi_i.x[31], bi_i.x};
  assign dy   = {bj_i.y[31], bj_i.y} - {bi_i.y[31], bi_i.y};
  assign absx = dx[32] ? (~dx + 33'd1) : dx;
  assign absy = dy[32] ? (~dy + 33'd1) : dy;

  // Squared distance, floor and magnitude saturation test.
  assign d2   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign dc   = (d2 < DIST_FLOOR) ? DIST_FLOOR : d2;
  assign fsat = ({24'd0, num_q} >= {dc, 31'd0});

  // One restoring divide step of the magnitude.
  assign dtry  = {dr_q, nsh_q[49]};
  assign dge   = (dtry >= {1'b0, dc_q});
  assign dnext = dge ? 67'(dtry - {1'b0, dc_q}) : dtry[66:0];

  // One digit step of the square root of the scaled distance.
  assign stry  = {srem_q[50:0], v_q[99:98]};
  assign trial = {1'b0, root_q, 2'b01};
  assign sge   = (stry >= trial);

  // One restoring divide step of the unit components.
  assign xtry = {rx_q, 1'b0};
  assign ytry = {ry_q, 1'b0};
  assign xge  = (xtry >= {1'b0, root_q});
  assign yge  = (ytry >= {1'b0, root_q});
  assign xsub = xtry - {1'b0, root_q};
  assign ysub = ytry - {1'b0, root_q};

  // Component scaling.
  assign uxv   = clx_q ? UNIT_ONE : {1'b0, qx_q};
  assign uyv   = cly_q ? UNIT_ONE : {1'b0, qy_q};
  assign prodx = {17'd0, f_q} * {47'd0, uxv};
  assign prody = {17'd0, f_q} * {47'd0, uyv};

  assign done_o = (state_q == P_DONE);
  assign res_o  = res_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      P_IDLE:  if (start_i) state_d = P_MUL;
      P_MUL:   state_d = P_PREP;
      P_PREP:  state_d = (d2 == '0) ? P_DONE : P_ROOT;
      P_ROOT:  if (cnt_q == 6'(ROOT_STEPS - 1)) state_d = P_UPREP;
      P_UPREP: state_d = P_UDIV;
      P_UDIV:  if (cnt_q == 6'(UNIT_STEPS - 1)) state_d = P_SCALE;
      P_SCALE: state_d = P_SIGN;
      P_SIGN:  state_d = P_DONE;
      P_DONE:  state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        ax_q <= absx;
        ay_q <= absy;
        sx_q <= dx[32];
        sy_q <= dy[32];
        mm_q <= {32'd0, bi_i.m} * {32'd0, bj_i.m};
      end
      P_MUL: begin
        sqx_q <= {33'd0, ax_q} * {33'd0, ax_q};
        sqy_q <= {33'd0, ay_q} * {33'd0, ay_q};
        num_q <= {10'd0, mm_q} * {64'd0, GRAV_K};
      end
      P_PREP: begin
        dc_q   <= dc;
        fsat_q <= fsat;
        dr_q   <= {27'd0, num_q[73:34]};
        nsh_q  <= {num_q[33:0], 16'd0};
        dq_q   <= '0;
        v_q    <= {1'b0, d2, 32'd0};
        root_q <= '0;
        srem_q <= '0;
        cnt_q  <= '0;
        res_q  <= '0;
      end
      P_ROOT: begin
        dr_q   <= dnext;
        nsh_q  <= {nsh_q[48:0], 1'b0};
        dq_q   <= {dq_q[48:0], dge};
        v_q    <= {v_q[97:0], 2'b00};
        srem_q <= sge ? 53'(stry - trial) : stry;
        root_q <= {root_q[48:0], sge};
        cnt_q  <= cnt_q + 1'b1;
      end
      P_UPREP: begin
        clx_q <= ({1'b0, ax_q, 16'd0} >= root_q);
        cly_q <= ({1'b0, ay_q, 16'd0} >= root_q);
        rx_q  <= {1'b0, ax_q, 16'd0};
        ry_q  <= {1'b0, ay_q, 16'd0};
        qx_q  <= '0;
        qy_q  <= '0;
        f_q   <= fsat_q ? FORCE_MAX[46:0] : dq_q[46:0];
        cnt_q <= '0;
      end
      P_UDIV: begin
        rx_q  <= xge ? xsub[49:0] : xtry[49:0];
        ry_q  <= yge ? ysub[49:0] : ytry[49:0];
        qx_q  <= {qx_q[14:0], xge};
        qy_q  <= {qy_q[14:0], yge};
        cnt_q <= cnt_q + 1'b1;
      end
      P_SCALE: begin
        px_q <= prodx[63:16];
        py_q <= prody[63:16];
      end
      P_SIGN: begin
        res_q.cx  <= sx_q ? -px_q : px_q;
        res_q.cy  <= sy_q ? -py_q : py_q;
        res_q.sat <= fsat_q;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/ngfa_back.sv =====
// ----------------------------------------------------------------------------
// ngfa_back
// Stores bodies, sequences all pairs of a set and emits one force per body.
// ----------------------------------------------------------------------------
module ngfa_back import ngfa_pkg::*; #(
  parameter int unsigned MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  cmd_t                      cmd_i,
  output logic                      pop_o,
  output logic                      result_valid_o,
  output logic [IDX_W-1:0]          body_index_o,
  output logic signed [FORCE_W-1:0] force_x_o,
  output logic signed [FORCE_W-1:0] force_y_o,
  output logic                      saturated_o,
  output logic                      last_force_o
);

  localparam int unsigned CW = $clog2(MAX_BODIES + 1);
  localparam int unsigned IW = $clog2(MAX_BODIES);

  back_state_e state_q, state_d;

  logic [CW-1:0] wptr_q, wptr_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic          we;
  logic [IW-1:0] raddr;
  body_t         rdata, bi_q;
  logic          pair_start, pair_done;
  pair_res_t     pair_res;
  logic signed [FORCE_W-1:0] sum_x_q, sum_y_q, sum_x_w, sum_y_w;
  logic [FORCE_W:0] addx, addy;
  logic          sat_q, clipx, clipy, last_i;

  // Body store.
  ngfa_ram #(
    .WIDTH($bits(body_t)),
    .DEPTH(MAX_BODIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wptr_q[IW-1:0]),
    .wdata_i(cmd_i.body),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Pair unit.
  ngfa_pair u_pair (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pair_start),
    .bi_i   (bi_q),
    .bj_i   (rdata),
    .done_o (pair_done),
    .res_o  (pair_res)
  );

  assign raddr      = (state_q == B_RD_I) ? i_q[IW-1:0] : j_q[IW-1:0];
  assign pair_start = (state_q == B_GET_J);
  assign last_i     = ((i_q + 1'b1) == n_q);

  // Saturating accumulation of one pair contribution.
  always_comb begin
    addx  = {sum_x_q[FORCE_W-1], sum_x_q} + {pair_res.cx[FORCE_W-1], pair_res.cx};
    addy  = {sum_y_q[FORCE_W-1], sum_y_q} + {pair_res.cy[FORCE_W-1], pair_res.cy};
    clipx = (addx[FORCE_W] != addx[FORCE_W-1]);
    clipy = (addy[FORCE_W] != addy[FORCE_W-1]);
    if (!clipx) begin
      sum_x_w = addx[FORCE_W-1:0];
    end else begin
      sum_x_w = addx[FORCE_W] ? FORCE_MIN : FORCE_MAX;
    end
    if (!clipy) begin
      sum_y_w = addy[FORCE_W-1:0];
    end else begin
      sum_y_w = addy[FORCE_W] ? FORCE_MIN : FORCE_MAX;
    end
  end

  // Sequencer over loads, bodies and pairs.
  always_comb begin
    state_d = state_q;
    wptr_d  = wptr_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          we    = cmd_i.keep;
          if (cmd_i.keep) begin
            wptr_d = wptr_q + 1'b1;
          end
          if (cmd_i.last) begin
            n_d     = cmd_i.keep ? wptr_q + 1'b1 : wptr_q;
            wptr_d  = '0;
            i_d     = '0;
            state_d = B_RD_I;
          end
        end
      end
      B_RD_I:  state_d = B_GET_I;
      B_GET_I: begin
        j_d     = '0;
        state_d = B_RD_J;
      end
      B_RD_J: begin
        if (j_q == n_q) begin
          state_d = B_EMIT;
        end else if (j_q == i_q) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = B_GET_J;
        end
      end
      B_GET_J: state_d = B_PAIR;
      B_PAIR: begin
        if (pair_done) begin
          j_d     = j_q + 1'b1;
          state_d = B_RD_J;
        end
      end
      B_EMIT: begin
        i_d     = i_q + 1'b1;
        state_d = last_i ? B_IDLE : B_RD_I;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      wptr_q  <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Body i operand and running sums.
  always_ff @(posedge clk_i) begin
    if (state_q == B_GET_I) begin
      bi_q    <= rdata;
      sum_x_q <= '0;
      sum_y_q <= '0;
      sat_q   <= 1'b0;
    end else if (state_q == B_PAIR && pair_done) begin
      sum_x_q <= sum_x_w;
      sum_y_q <= sum_y_w;
      sat_q   <= sat_q | pair_res.sat | clipx | clipy;
    end
  end

  // Result strobe.
  assign result_valid_o = (state_q == B_EMIT);
  assign body_index_o   = IDX_W'(i_q);
  assign force_x_o      = sum_x_q;
  assign force_y_o      = sum_y_q;
  assign saturated_o    = sat_q;
  assign last_force_o   = (state_q == B_EMIT) && last_i;

endmodule

// ===== rtl/nbody_gravity_force_accumulate_top.sv =====
// ----------------------------------------------------------------------------
// nbody_gravity_force_accumulate_top
// Direct-sum 2D gravity: loads bodies, then emits the summed force on each.
// ----------------------------------------------------------------------------
// Bodies are loaded one per transaction (start_i with busy_o low); the body
// marked last_body_i starts the computation. Loads pass through a two-entry
// queue, so busy_o rises only once that queue is full while a set is being
// computed. Pairs are evaluated one at a time in the single iterative pair
// unit (a 50-step combined divide and square root, then a 16-step unit-vector
// divide, plus store reads and setup); a coincident pair skips both divides.
// Results appear on result_valid_o for exactly one cycle each, in load
// order, and the receiver cannot stall them. There is no clearing pass after
// reset.
module nbody_gravity_force_accumulate_top import ngfa_pkg::*; #(
  parameter int unsigned MAX_BODIES = MAX_BODIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [POS_W-1:0]   body_x_i,
  input  logic signed [POS_W-1:0]   body_y_i,
  input  logic [MASS_W-1:0]         body_mass_i,
  input  logic                      last_body_i,
  output logic                      result_valid_o,
  output logic [IDX_W-1:0]          body_index_o,
  output logic signed [FORCE_W-1:0] force_x_o,
  output logic signed [FORCE_W-1:0] force_y_o,
  output logic                      saturated_o,
  output logic                      last_force_o
);

  logic push, pop, full, empty;
  cmd_t cmd_in, cmd_out;

  assign busy_o = full;

  // Load front.
  ngfa_front #(.MAX_BODIES(MAX_BODIES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .body_x_i   (body_x_i),
    .body_y_i   (body_y_i),
    .body_mass_i(body_mass_i),
    .last_body_i(last_body_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // Command queue.
  ngfa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .full_o (full),
    .empty_o(empty)
  );

  // Compute back.
  ngfa_back #(.MAX_BODIES(MAX_BODIES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .body_index_o  (body_index_o),
    .force_x_o     (force_x_o),
    .force_y_o     (force_y_o),
    .saturated_o   (saturated_o),
    .last_force_o  (last_force_o)
  );

endmodule

// ===== rtl/ngfa_checker.sv =====
// ----------------------------------------------------------------------------
// ngfa_checker
// Port-level checks of the result strobe, bound to the top level.
// ----------------------------------------------------------------------------
module ngfa_checker import ngfa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic result_valid_o,
  input logic last_force_o
);

  // Results are never back to back.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // The end-of-set mark only travels with a result.
  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_force_o |-> result_valid_o)
    else $error("last_force_o without a result");

  // Reset suppresses results.
  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !result_valid_o)
    else $error("result strobe during reset");

  // After the last result of a set, the next cycle carries no end-of-set mark.
  a_last_ends_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_force_o) |=> !last_force_o)
    else $error("two end-of-set marks in a row");

endmodule

bind nbody_gravity_force_accumulate_top ngfa_checker u_ngfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .result_valid_o(result_valid_o),
  .last_force_o  (last_force_o)
);
